// ===== rtl/prdq_pkg.sv =====
package prdq_pkg;

   localparam int CapacityDefault = 64;
   localparam logic [6:0] QueueLimitReset = 7'd64;
   localparam logic [15:0] SizeThresholdReset = 16'd1460;
   localparam int EntryWidth = 32;

   localparam logic KindEnqueue = 1'b0;
   localparam logic KindDequeue = 1'b1;

   typedef enum logic {
      CSR_QUEUE_LIMIT    = 1'b0,
      CSR_SIZE_THRESHOLD = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CTRL_READ,
      ST_DIV,
      ST_BULK_READ,
      ST_SHIFT_READ,
      ST_SHIFT_WRITE,
      ST_EMIT,
      ST_HOLD
   } state_type;

endpackage

// ===== rtl/priority_random_dequeue_queue_unit.sv =====
// Two-bin packet-descriptor queue with random service of the bulk bin.
// Requests arrive on the req_ stream: tdata carries kind, packet_tag,
// packet_size and random_value. Each transfer produces exactly one response
// on the rsp_ stream with accepted, out_valid, out_tag, out_size,
// from_control, queued_count and queued_bytes.
// Descriptors below size_threshold go to a FIFO control bin; others are
// appended to an ordered bulk bin. Dequeue serves the control head first,
// otherwise it removes the bulk entry at random_value mod bulk_count and
// shifts later entries down one place.
// An enqueue goes through ST_EMIT and ST_HOLD; a control dequeue first passes
// ST_CTRL_READ; a bulk dequeue first runs the 16-step bit-serial remainder in
// ST_DIV, ST_BULK_READ, and ST_SHIFT_READ/ST_SHIFT_WRITE for each later entry.
// One request is in flight at a time; req_tready is low while it is worked on.
// Reset clears state, counts, head pointer and byte total; RAM is not cleared.
// When the receiver stalls, the response holds and no new request is taken.
// Configuration writes on the csr_ channel are always taken.
module priority_random_dequeue_queue_unit
   import prdq_pkg::*;
#(
   parameter int Capacity = CapacityDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind[0], packet_tag[16:1], packet_size[32:17], random_value[48:33]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // accepted[0], out_valid[1], out_tag[17:2], out_size[33:18],
   // from_control[34], queued_count[41:35], queued_bytes[63:42]
   output logic [63:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   localparam int AddrWidth = $clog2(Capacity);
   localparam int CountWidth = $clog2(Capacity + 1);

   state_type state_ff, state_in;

   logic [6:0]  queue_limit_ff;
   logic [15:0] size_threshold_ff;
   logic [CountWidth-1:0] ctrl_count_ff, ctrl_count_in;
   logic [CountWidth-1:0] bulk_count_ff, bulk_count_in;
   logic [AddrWidth-1:0]  ctrl_head_ff, ctrl_head_in;
   logic [21:0] bytes_ff, bytes_in;

   logic [15:0] rnd_ff, rnd_in;
   logic [15:0] rem_ff, rem_in;
   logic [4:0]  step_ff, step_in;
   logic [AddrWidth-1:0] pos_ff, pos_in;
   logic [63:0] rsp_ff, rsp_in;

   logic                  cw_en, bw_en;
   logic [AddrWidth-1:0]  cw_addr, cr_addr, bw_addr, br_addr;
   logic [EntryWidth-1:0] cw_data, bw_data, c_rd, b_rd;

   prdq_ram #(.Width(EntryWidth), .Depth(Capacity)) u_ctrl_ram (
      .clock, .wr_en(cw_en), .wr_addr(cw_addr), .wr_data(cw_data),
      .rd_addr(cr_addr), .rd_data(c_rd));

   prdq_ram #(.Width(EntryWidth), .Depth(Capacity)) u_bulk_ram (
      .clock, .wr_en(bw_en), .wr_addr(bw_addr), .wr_data(bw_data),
      .rd_addr(br_addr), .rd_data(b_rd));

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_limit_ff    <= QueueLimitReset;
         size_threshold_ff <= SizeThresholdReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_QUEUE_LIMIT:    queue_limit_ff    <= csr_data[6:0];
            CSR_SIZE_THRESHOLD: size_threshold_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic        kind;
   logic [15:0] p_tag, p_size, p_rnd;
   assign kind   = req_tdata[0];
   assign p_tag  = req_tdata[16:1];
   assign p_size = req_tdata[32:17];
   assign p_rnd  = req_tdata[48:33];

   logic [CountWidth:0] total, limit;
   logic [16:0] rem_shift;
   logic [16:0] rem_sub;
   logic [AddrWidth:0] tail_sum;

   assign total = {1'b0, ctrl_count_ff} + {1'b0, bulk_count_ff};
   assign limit = ({{(CountWidth > 7 ? CountWidth - 6 : 1){1'b0}}, queue_limit_ff}
                   > (CountWidth+1)'(Capacity))
                  ? (CountWidth+1)'(Capacity)
                  : (CountWidth+1)'(queue_limit_ff);
   assign rem_shift = {rem_ff, rnd_ff[15]};
   assign rem_sub   = rem_shift - 17'(bulk_count_ff);
   assign tail_sum  = {1'b0, ctrl_head_ff} + AddrWidth'(ctrl_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ctrl_count_ff <= '0;
         bulk_count_ff <= '0;
         ctrl_head_ff  <= '0;
         bytes_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         ctrl_count_ff <= ctrl_count_in;
         bulk_count_ff <= bulk_count_in;
         ctrl_head_ff  <= ctrl_head_in;
         bytes_ff      <= bytes_in;
      end
      rnd_ff   <= rnd_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      pos_ff   <= pos_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      ctrl_count_in = ctrl_count_ff;
      bulk_count_in = bulk_count_ff;
      ctrl_head_in  = ctrl_head_ff;
      bytes_in      = bytes_ff;
      rnd_in        = rnd_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      pos_in        = pos_ff;
      rsp_in        = rsp_ff;
      cw_en   = 1'b0;
      cw_addr = (tail_sum >= (AddrWidth+1)'(Capacity))
                ? AddrWidth'(tail_sum - (AddrWidth+1)'(Capacity))
                : AddrWidth'(tail_sum);
      cw_data = {p_tag, p_size};
      cr_addr = ctrl_head_ff;
      bw_en   = 1'b0;
      bw_addr = AddrWidth'(bulk_count_ff);
      bw_data = {p_tag, p_size};
      br_addr = pos_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rsp_in = '0;
               rnd_in = p_rnd;
               if (kind == KindEnqueue) begin
                  if (total < limit) begin
                     rsp_in[0] = 1'b1;
                     bytes_in = bytes_ff + 22'(p_size);
                     if (p_size >= size_threshold_ff) begin
                        bw_en = 1'b1;
                        bulk_count_in = bulk_count_ff + 1'b1;
                     end else begin
                        cw_en = 1'b1;
                        ctrl_count_in = ctrl_count_ff + 1'b1;
                     end
                  end
                  state_in = ST_EMIT;
               end else if (ctrl_count_ff != '0) begin
                  state_in = ST_CTRL_READ;
               end else if (bulk_count_ff != '0) begin
                  rem_in  = '0;
                  step_in = '0;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_CTRL_READ: begin
            rsp_in[1]     = 1'b1;
            rsp_in[17:2]  = c_rd[31:16];
            rsp_in[33:18] = c_rd[15:0];
            rsp_in[34]    = 1'b1;
            bytes_in = bytes_ff - 22'(c_rd[15:0]);
            ctrl_count_in = ctrl_count_ff - 1'b1;
            ctrl_head_in = (32'(ctrl_head_ff) == Capacity - 1) ? '0 : ctrl_head_ff + 1'b1;
            state_in = ST_EMIT;
         end
         ST_DIV: begin
            // One restoring-division step per cycle, MSB first.
            if (!rem_sub[16]) rem_in = rem_sub[15:0];
            else rem_in = rem_shift[15:0];
            rnd_in  = {rnd_ff[14:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd15) begin
               pos_in = AddrWidth'(!rem_sub[16] ? rem_sub[15:0] : rem_shift[15:0]);
               state_in = ST_BULK_READ;
            end
         end
         ST_BULK_READ: begin
            br_addr = pos_ff;
            state_in = ST_SHIFT_READ;
            step_in = '0;
         end
         ST_SHIFT_READ: begin
            if (step_ff == '0) begin
               rsp_in[1]     = 1'b1;
               rsp_in[17:2]  = b_rd[31:16];
               rsp_in[33:18] = b_rd[15:0];
               bytes_in = bytes_ff - 22'(b_rd[15:0]);
            end
            if ({1'b0, pos_ff} + 1'b1 < (AddrWidth+1)'(bulk_count_ff)) begin
               br_addr = pos_ff + 1'b1;
               state_in = ST_SHIFT_WRITE;
            end else begin
               bulk_count_in = bulk_count_ff - 1'b1;
               state_in = ST_EMIT;
            end
            step_in = 5'd1;
         end
         ST_SHIFT_WRITE: begin
            bw_en   = 1'b1;
            bw_addr = pos_ff;
            bw_data = b_rd;
            pos_in  = pos_ff + 1'b1;
            br_addr = pos_ff + 1'b1;
            state_in = ST_SHIFT_READ;
         end
         ST_EMIT: begin
            rsp_in[41:35] = 7'(total);
            rsp_in[63:42] = bytes_ff;
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tdata = rsp_ff;

   logic unused;
   assign unused = ^{req_tdata[55:49]};

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      total <= (CountWidth+1)'(Capacity)) else $error("count over capacity");
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while holding response");
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("response changed");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BULK_READ |-> (AddrWidth+1)'(pos_ff) < (AddrWidth+1)'(bulk_count_ff))
      else $error("bulk position out of range");
`endif

endmodule

// ===== rtl/prdq_ram.sv =====
module prdq_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
